FILE: design/nsrh_pkg.sv
package nsrh_pkg;

  localparam int unsigned HashW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned PosW   = 4;
  localparam int unsigned Rounds = 10;
  localparam int unsigned KeyStp = 3;
  localparam int unsigned RotW   = 5;

  typedef logic [HashW-1:0] hash_t;
  typedef logic [NibW-1:0]  nib_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [RotW-1:0]  rot_t;

  localparam logic [PosW-1:0] PosLast = 4'hF;

  // pi digit words selected by a nibble
  function automatic hash_t pi_word(input nib_t idx);
    hash_t w;
    case (idx)
      4'h0: w = 32'h243F6A88;
      4'h1: w = 32'h85A308D3;
      4'h2: w = 32'h3198A2E0;
      4'h3: w = 32'h3707344A;
      4'h4: w = 32'h40938222;
      4'h5: w = 32'h99F31D00;
      4'h6: w = 32'h82EFA98E;
      4'h7: w = 32'hC4E6C894;
      4'h8: w = 32'h52821E63;
      4'h9: w = 32'h8D01377B;
      4'hA: w = 32'hE5466CF3;
      4'hB: w = 32'h4E90C6CC;
      4'hC: w = 32'h0AC29B7C;
      4'hD: w = 32'h97C50DD3;
      4'hE: w = 32'hF84D5B5B;
      default: w = 32'h54709179;
    endcase
    return w;
  endfunction

  // rotate left by a 5-bit amount, zero leaves the word alone
  function automatic hash_t rotl(input hash_t v, input rot_t n);
    logic [2*HashW-1:0] dbl;
    logic [2*HashW-1:0] sh;
    dbl = {v, v};
    sh  = dbl << n;
    return sh[2*HashW-1 -: HashW];
  endfunction

endpackage

FILE: design/nsrh_mix.sv
module nsrh_mix
  import nsrh_pkg::*;
(
  input  hash_t             state_i,
  input  logic [ByteW-1:0]  data_i,
  output hash_t             state_o
);

  hash_t hi_x;
  hash_t hi_r;
  hash_t lo_x;

  // high nibble first, each followed by a right rotate by one
  always_comb begin
    hi_x    = state_i ^ pi_word(data_i[ByteW-1 -: NibW]);
    hi_r    = {hi_x[0], hi_x[HashW-1:1]};
    lo_x    = hi_r ^ pi_word(data_i[NibW-1:0]);
    state_o = {lo_x[0], lo_x[HashW-1:1]};
  end

endmodule

FILE: design/nsrh_perm.sv
module nsrh_perm
  import nsrh_pkg::*;
(
  input  hash_t state_i,
  output hash_t state_o
);

  // each round's key is the low three bits of the input rotated left by 3*r;
  // the whole permutation is one rotate left by the sum of the key bits, mod 32
  logic [6:0] amt_sum;
  hash_t      key_rot;

  always_comb begin
    amt_sum = '0;
    key_rot = '0;
    for (int r = 0; r < Rounds; r++) begin
      key_rot = rotl(state_i, rot_t'(KeyStp * r));
      amt_sum = amt_sum + {4'b0, key_rot[2:0]};
    end
    state_o = rotl(state_i, amt_sum[RotW-1:0]);
  end

endmodule

FILE: design/nibble_sbox_rotate_hash32.sv
// channel | ports                                  | transfer when
// --------+----------------------------------------+--------------------------
// input   | in_valid in_ready in_data_byte         | in_valid && in_ready
//         | in_last_byte                           |
// result  | out_valid out_ready out_hash_value     | out_valid && out_ready
//
// one byte per cycle sustained while no last byte waits on a full result;
// a byte goes through the input register, then the nibble mix (and the
// permutation at position 15) updates the state. the hash of a message is
// presented at the edge where its last byte leaves the input register.
// reset clears state, position and all valid flags.
// a stalled result only blocks the next last byte; other bytes keep flowing.
module nibble_sbox_rotate_hash32
  import nsrh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HashW-1:0]  out_hash_value
);

  logic             s1_valid_r;
  logic [ByteW-1:0] s1_data_r;
  logic             s1_last_r;
  hash_t            state_r;
  pos_t             pos_r;
  logic             out_valid_r;
  hash_t            out_hash_r;

  logic  s1_adv;
  hash_t mixed;
  hash_t permuted;
  hash_t state_nxt;

  // stage one may move on unless it holds a last byte and the result is full and not being taken
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  nsrh_mix u_mix (
    .state_i (state_r),
    .data_i  (s1_data_r),
    .state_o (mixed)
  );

  nsrh_perm u_perm (
    .state_i (mixed),
    .state_o (permuted)
  );

  assign state_nxt = (pos_r == PosLast) ? permuted : mixed;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // running hash state and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      pos_r   <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        state_r <= '0;
        pos_r   <= '0;
      end else begin
        state_r <= state_nxt;
        pos_r   <= pos_r + pos_t'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      out_hash_r <= state_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule
